>>> rtl/four_char_word_machine_core_assert.svh
// ----------------------------------------------------------------------------
// four_char_word_machine_core_assert.svh
// Assertion macros used by the checker of the word machine core.
// ----------------------------------------------------------------------------
`ifndef FOUR_CHAR_WORD_MACHINE_CORE_ASSERT_SVH
`define FOUR_CHAR_WORD_MACHINE_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define FCWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define FCWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fcwm_pkg.sv
// ----------------------------------------------------------------------------
// fcwm_pkg
// Types and constants of the four-character word machine core.
// ----------------------------------------------------------------------------
package fcwm_pkg;

  localparam int unsigned ADDR_W = 7;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = 3;

  localparam logic [7:0]        CHAR_NUL    = 8'h00;
  localparam logic [7:0]        CHAR_DOLLAR = 8'h24;
  localparam logic [7:0]        CHAR_ZERO   = 8'd48;
  localparam logic [7:0]        CHAR_NINE   = 8'd57;
  localparam logic [WORD_W-1:0] ALL_DOLLARS = 32'h2424_2424;

  // opcode character pairs
  localparam logic [15:0] OPC_LR = 16'h4C52;
  localparam logic [15:0] OPC_SR = 16'h5352;
  localparam logic [15:0] OPC_CR = 16'h4352;
  localparam logic [15:0] OPC_BT = 16'h4254;
  localparam logic [15:0] OPC_GD = 16'h4744;
  localparam logic [15:0] OPC_PD = 16'h5044;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_START = 2'd2,
    KIND_STEP  = 2'd3
  } fcwm_kind_e;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_INREQ   = 3'd1,
    ST_OUT     = 3'd2,
    ST_HALT    = 3'd3,
    ST_ADDRERR = 3'd4
  } fcwm_status_e;

  typedef enum logic [2:0] {
    OP_LR  = 3'd0,
    OP_SR  = 3'd1,
    OP_CR  = 3'd2,
    OP_BT  = 3'd3,
    OP_GD  = 3'd4,
    OP_PD  = 3'd5,
    OP_BAD = 3'd6
  } fcwm_op_e;

  // source of the address field of a single result
  typedef enum logic [1:0] {
    RA_IA   = 2'd0,
    RA_IN   = 2'd1,
    RA_ZERO = 2'd2,
    RA_BASE = 2'd3
  } fcwm_raddr_e;

  typedef struct packed {
    logic         latch_in;
    logic         wr_load;
    logic         wr_reg;
    logic         rd_ic;
    logic         rd_pos;
    logic         rd_ptr;
    logic         clear_all;
    logic         start;
    logic         decode;
    logic         ic_branch;
    logic         halt_set;
    logic         lr_load;
    logic         cr_eval;
    logic         base_load;
    logic         pd_adv;
    logic         res_set;
    fcwm_status_e res_status;
    fcwm_raddr_e  res_addr;
    logic         out_single;
    logic         out_pd;
  } fcwm_cmd_t;

  typedef struct packed {
    fcwm_kind_e kind;
    logic       halted;
    logic       ic_oob;
    fcwm_op_e   op;
    fcwm_op_e   op_q;
    logic       cf;
    logic       pos_ok;
    logic       slot_free;
    logic       pd_stop;
  } fcwm_sts_t;

endpackage

>>> rtl/fcwm_ctrl.sv
// ----------------------------------------------------------------------------
// fcwm_ctrl
// Sequencer of the word machine: dispatches items, walks instruction steps.
// ----------------------------------------------------------------------------
module fcwm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fcwm_pkg::fcwm_sts_t sts_i,
  output fcwm_pkg::fcwm_cmd_t cmd_o
);
  import fcwm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DISPATCH = 8'b0000_0010,
    S_DECODE   = 8'b0000_0100,
    S_OPER     = 8'b0000_1000,
    S_BASE     = 8'b0001_0000,
    S_PD_RD    = 8'b0010_0000,
    S_PD_OUT   = 8'b0100_0000,
    S_EMIT     = 8'b1000_0000
  } fcwm_state_e;

  fcwm_state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d       = S_EMIT;
        cmd_o.res_set = 1'b1;
        case (sts_i.kind)
          KIND_LOAD: begin
            cmd_o.wr_load  = 1'b1;
            cmd_o.res_addr = RA_IN;
          end
          KIND_CLEAR: begin
            cmd_o.clear_all = 1'b1;
            cmd_o.res_addr  = RA_ZERO;
          end
          KIND_START: begin
            cmd_o.start    = 1'b1;
            cmd_o.res_addr = RA_ZERO;
          end
          default: begin
            if (sts_i.halted) begin
              cmd_o.res_status = ST_HALT;
            end else if (sts_i.ic_oob) begin
              cmd_o.halt_set   = 1'b1;
              cmd_o.res_status = ST_ADDRERR;
            end else begin
              cmd_o.res_set = 1'b0;
              cmd_o.rd_ic   = 1'b1;
              state_d       = S_DECODE;
            end
          end
        endcase
      end
      S_DECODE: begin
        cmd_o.decode  = 1'b1;
        cmd_o.res_set = 1'b1;
        state_d       = S_EMIT;
        if (sts_i.op == OP_BAD) begin
          cmd_o.halt_set   = 1'b1;
          cmd_o.res_status = ST_HALT;
        end else if (sts_i.op == OP_BT && !sts_i.cf) begin
          cmd_o.res_status = ST_DONE;
        end else if (!sts_i.pos_ok) begin
          cmd_o.halt_set   = 1'b1;
          cmd_o.res_status = ST_ADDRERR;
        end else begin
          case (sts_i.op)
            OP_LR, OP_CR: begin
              cmd_o.res_set = 1'b0;
              cmd_o.rd_pos  = 1'b1;
              state_d       = S_OPER;
            end
            OP_SR: cmd_o.wr_reg = 1'b1;
            OP_BT: cmd_o.ic_branch = 1'b1;
            default: begin
              cmd_o.res_set = 1'b0;
              state_d       = S_BASE;
            end
          endcase
        end
      end
      S_OPER: begin
        cmd_o.res_set = 1'b1;
        cmd_o.lr_load = (sts_i.op_q == OP_LR);
        cmd_o.cr_eval = (sts_i.op_q == OP_CR);
        state_d       = S_EMIT;
      end
      S_BASE: begin
        cmd_o.base_load = 1'b1;
        if (sts_i.op_q == OP_GD) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_INREQ;
          cmd_o.res_addr   = RA_BASE;
          state_d          = S_EMIT;
        end else begin
          state_d = S_PD_RD;
        end
      end
      S_PD_RD: begin
        cmd_o.rd_ptr = 1'b1;
        state_d      = S_PD_OUT;
      end
      S_PD_OUT: begin
        if (sts_i.slot_free) begin
          cmd_o.out_pd = 1'b1;
          if (sts_i.pd_stop) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.pd_adv = 1'b1;
            state_d      = S_PD_RD;
          end
        end
      end
      S_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.out_single = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/fcwm_dp.sv
// ----------------------------------------------------------------------------
// fcwm_dp
// Datapath: word store, machine registers, operand decode, output register.
// ----------------------------------------------------------------------------
module fcwm_dp #(
  parameter int unsigned STORE_WORDS = 100,
  parameter int unsigned BLOCK_WORDS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [1:0]                      kind_i,
  input  logic [fcwm_pkg::ADDR_W-1:0]     address_i,
  input  logic [fcwm_pkg::WORD_W-1:0]     word_i,
  input  fcwm_pkg::fcwm_cmd_t             cmd_i,
  output fcwm_pkg::fcwm_sts_t             sts_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      status_o,
  output logic [fcwm_pkg::ADDR_W-1:0]     address_res_o,
  output logic [fcwm_pkg::WORD_W-1:0]     word_res_o,
  output logic [fcwm_pkg::CNT_W-1:0]      byte_count_o,
  output logic                            last_o
);
  import fcwm_pkg::*;

  localparam int unsigned AW        = $clog2(STORE_WORDS);
  localparam int unsigned IW        = $clog2(BLOCK_WORDS + 1);
  localparam int unsigned DIV_SHIFT = 16;
  localparam int unsigned RECIP     = (2**DIV_SHIFT + BLOCK_WORDS - 1) / BLOCK_WORDS;
  localparam int unsigned RW        = DIV_SHIFT + 1;
  localparam int unsigned PW        = ADDR_W + RW;

  localparam logic [ADDR_W-1:0] SW_V    = ADDR_W'(STORE_WORDS);
  localparam logic [ADDR_W:0]   SW_V8   = (ADDR_W + 1)'(STORE_WORDS);
  localparam logic [RW-1:0]     RECIP_V = RW'(RECIP);
  localparam logic [3:0]        BLK_V   = 4'(BLOCK_WORDS);
  localparam logic [IW:0]       BLK_CNT = (IW + 1)'(BLOCK_WORDS);

  // opcode from the upper character pair
  function automatic fcwm_op_e op_decode(input logic [15:0] opc);
    fcwm_op_e op;
    case (opc)
      OPC_LR:  op = OP_LR;
      OPC_SR:  op = OP_SR;
      OPC_CR:  op = OP_CR;
      OPC_BT:  op = OP_BT;
      OPC_GD:  op = OP_GD;
      OPC_PD:  op = OP_PD;
      default: op = OP_BAD;
    endcase
    return op;
  endfunction

  // bytes ahead of the first '$' or NUL
  function automatic logic [CNT_W-1:0] lead_bytes(input logic [WORD_W-1:0] w);
    logic [CNT_W-1:0] n;
    logic             stop;
    logic [7:0]       c;
    n    = '0;
    stop = 1'b0;
    for (int b = 0; b < 4; b++) begin
      c = w[31-8*b -: 8];
      if (!stop && (c == CHAR_NUL || c == CHAR_DOLLAR)) begin
        stop = 1'b1;
      end else if (!stop) begin
        n = n + CNT_W'(1);
      end
    end
    return n;
  endfunction

  // latched item
  fcwm_kind_e        kind_q;
  logic [ADDR_W-1:0] addr_q;
  logic [WORD_W-1:0] word_q;

  // machine state
  logic [ADDR_W-1:0] ic_q, ia_q;
  logic              halted_q, rv_q, cf_q;
  logic [WORD_W-1:0] gr_q;
  fcwm_op_e          op_q;
  logic [ADDR_W-1:0] blk_q, base_q, ptr_q;
  logic [IW-1:0]     i_q;

  // pending single result
  fcwm_status_e      res_status_q;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;

  // store
  logic [WORD_W-1:0]      mem [STORE_WORDS];
  logic [STORE_WORDS-1:0] vld_q;
  logic [WORD_W-1:0]      rd_data_q;
  logic                   rd_vld_q;
  logic [WORD_W-1:0]      rd_word;
  logic                   we, rd_en;
  logic [ADDR_W-1:0]      wa, ra;
  logic [WORD_W-1:0]      wd;

  // operand decode
  logic [7:0]        hi_c, lo_c;
  logic              hi_ok, lo_ok;
  logic [ADDR_W-1:0] pos;
  fcwm_op_e          op;
  logic [PW-1:0]     prod;
  logic [10:0]       base_prod;
  logic [ADDR_W-1:0] base_w;

  // output word
  logic [CNT_W-1:0]  n_bytes;
  logic [WORD_W-1:0] mask;
  logic [IW:0]       i_nxt;
  logic [ADDR_W:0]   ptr_nxt;
  logic              pd_stop;

  // output register
  logic              out_valid_q;
  logic [2:0]        out_status_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [WORD_W-1:0] out_word_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic              out_last_q;
  logic              slot_free;

  assign rd_word = rd_vld_q ? rd_data_q : ALL_DOLLARS;

  assign hi_c  = rd_word[15:8];
  assign lo_c  = rd_word[7:0];
  assign hi_ok = (hi_c >= CHAR_ZERO) && (hi_c <= CHAR_NINE);
  assign lo_ok = (lo_c >= CHAR_ZERO) && (lo_c <= CHAR_NINE);
  assign pos   = ADDR_W'({3'b000, hi_c[3:0]} * 7'd10) + {3'b000, lo_c[3:0]};
  assign op    = op_decode(rd_word[31:16]);

  // block number by reciprocal multiply, exact for 7-bit operands
  assign prod      = PW'(pos) * PW'(RECIP_V);
  assign base_prod = 11'(blk_q) * 11'(BLK_V);
  assign base_w    = base_prod[ADDR_W-1:0];

  assign n_bytes = lead_bytes(rd_word);
  always_comb begin
    case (n_bytes)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'hFF00_0000;
      3'd2:    mask = 32'hFFFF_0000;
      3'd3:    mask = 32'hFFFF_FF00;
      default: mask = 32'hFFFF_FFFF;
    endcase
  end
  assign i_nxt   = {1'b0, i_q} + (IW + 1)'(1);
  assign ptr_nxt = {1'b0, ptr_q} + (ADDR_W + 1)'(1);
  assign pd_stop = (n_bytes != 3'd4) || (i_nxt >= BLK_CNT) || (ptr_nxt >= SW_V8);

  // store ports
  assign we    = (cmd_i.wr_load && (addr_q < SW_V)) || cmd_i.wr_reg;
  assign wa    = cmd_i.wr_reg ? pos : addr_q;
  assign wd    = cmd_i.wr_reg ? gr_q : word_q;
  assign rd_en = cmd_i.rd_ic || cmd_i.rd_pos || cmd_i.rd_ptr;
  assign ra    = cmd_i.rd_ic ? ic_q : (cmd_i.rd_pos ? pos : ptr_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa[AW-1:0]] <= wd;
    end
    if (rd_en) begin
      rd_data_q <= mem[ra[AW-1:0]];
      rd_vld_q  <= vld_q[ra[AW-1:0]];
    end
  end

  // written-entry bits; an unwritten entry reads as all '$'
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.clear_all) begin
      vld_q <= '0;
    end else if (we) begin
      vld_q[wa[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      kind_q <= fcwm_kind_e'(kind_i);
      addr_q <= address_i;
      word_q <= word_i;
      ia_q   <= ic_q;
    end
    if (cmd_i.decode) begin
      op_q  <= op;
      blk_q <= prod[DIV_SHIFT +: ADDR_W];
    end
    if (cmd_i.base_load) begin
      base_q <= base_w;
      ptr_q  <= base_w;
      i_q    <= '0;
    end else if (cmd_i.pd_adv) begin
      ptr_q <= ptr_nxt[ADDR_W-1:0];
      i_q   <= i_nxt[IW-1:0];
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_addr_q   <= res_addr_d;
    end
  end

  always_comb begin
    case (cmd_i.res_addr)
      RA_IA:   res_addr_d = ia_q;
      RA_IN:   res_addr_d = addr_q;
      RA_ZERO: res_addr_d = '0;
      RA_BASE: res_addr_d = base_w;
      default: res_addr_d = ia_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q     <= '0;
      halted_q <= 1'b1;
      gr_q     <= '0;
      rv_q     <= 1'b0;
      cf_q     <= 1'b0;
    end else begin
      if (cmd_i.clear_all) begin
        ic_q     <= '0;
        halted_q <= 1'b1;
        gr_q     <= '0;
        rv_q     <= 1'b0;
        cf_q     <= 1'b0;
      end
      if (cmd_i.start) begin
        ic_q     <= '0;
        halted_q <= 1'b0;
      end
      if (cmd_i.decode) begin
        ic_q <= ia_q + ADDR_W'(1);
      end
      if (cmd_i.ic_branch) begin
        ic_q <= pos;
      end
      if (cmd_i.halt_set) begin
        halted_q <= 1'b1;
      end
      if (cmd_i.lr_load) begin
        gr_q <= rd_word;
        rv_q <= 1'b1;
      end
      if (cmd_i.cr_eval) begin
        cf_q <= rv_q && (gr_q == rd_word);
      end
    end
  end

  // output register
  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_single || cmd_i.out_pd) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_single) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_word_q   <= '0;
      out_cnt_q    <= '0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.out_pd) begin
      out_status_q <= ST_OUT;
      out_addr_q   <= base_q;
      out_word_q   <= rd_word & mask;
      out_cnt_q    <= n_bytes;
      out_last_q   <= pd_stop;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign address_res_o = out_addr_q;
  assign word_res_o    = out_word_q;
  assign byte_count_o  = out_cnt_q;
  assign last_o        = out_last_q;

  assign sts_o.kind      = kind_q;
  assign sts_o.halted    = halted_q;
  assign sts_o.ic_oob    = (ic_q >= SW_V);
  assign sts_o.op        = op;
  assign sts_o.op_q      = op_q;
  assign sts_o.cf        = cf_q;
  assign sts_o.pos_ok    = hi_ok && lo_ok && (pos < SW_V);
  assign sts_o.slot_free = slot_free;
  assign sts_o.pd_stop   = pd_stop;

endmodule

>>> rtl/four_char_word_machine_core.sv
// ----------------------------------------------------------------------------
// four_char_word_machine_core
// Core of a small machine with four-character words and a six-op instruction set.
// ----------------------------------------------------------------------------
// One item is in work at a time; the sequencer in fcwm_ctrl walks it through
// the word store in fcwm_dp, whose read data is registered. From one accept
// to the next: load, clear and start, and a step that is halted or whose
// counter is past the store, go through dispatch and emit; an unknown op, an
// untaken BT, a bad operand, SR or a taken BT also pass through decode; LR and
// CR add an operand read after decode and GD a block base state (a second
// store read, or the block base multiply); PD reads and outputs the words of
// its block in turn, up to all ten of a ten-word block.
// Results sit in an output register, so a downstream stall only holds the
// core when a second result is ready to go. The store keeps one written bit
// per word: clear drops them all together, so there is no clearing pass
// after reset, and an unwritten word reads as four '$' characters.
module four_char_word_machine_core #(
  parameter int unsigned STORE_WORDS = 100,
  parameter int unsigned BLOCK_WORDS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  kind_i,
  input  logic [fcwm_pkg::ADDR_W-1:0] address_i,
  input  logic [fcwm_pkg::WORD_W-1:0] word_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  status_o,
  output logic [fcwm_pkg::ADDR_W-1:0] address_res_o,
  output logic [fcwm_pkg::WORD_W-1:0] word_res_o,
  output logic [fcwm_pkg::CNT_W-1:0]  byte_count_o,
  output logic                        last_o
);
  import fcwm_pkg::*;

  fcwm_cmd_t cmd;
  fcwm_sts_t sts;

  // sequencer: one-hot states, issues store reads/writes and result loads
  fcwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // store, IC/GR/flags, operand decode, PD byte scan, output register
  fcwm_dp #(
    .STORE_WORDS (STORE_WORDS),
    .BLOCK_WORDS (BLOCK_WORDS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (kind_i),
    .address_i     (address_i),
    .word_i        (word_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .address_res_o (address_res_o),
    .word_res_o    (word_res_o),
    .byte_count_o  (byte_count_o),
    .last_o        (last_o)
  );

endmodule

>>> rtl/fcwm_checker.sv
// ----------------------------------------------------------------------------
// fcwm_checker
// Port-level checks of the word machine core, bound to the top level.
// ----------------------------------------------------------------------------
`include "four_char_word_machine_core_assert.svh"

module fcwm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [2:0]                  status_o,
  input logic [fcwm_pkg::ADDR_W-1:0] address_res_o,
  input logic [fcwm_pkg::WORD_W-1:0] word_res_o,
  input logic [fcwm_pkg::CNT_W-1:0]  byte_count_o,
  input logic                        last_o
);
  import fcwm_pkg::*;

  // stalled result holds
  `FCWM_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(status_o) && $stable(address_res_o) &&
    $stable(word_res_o) && $stable(byte_count_o) && $stable(last_o),
    "result changed while stalled")

  // only output words carry data, and every other result ends its item
  `FCWM_ASSERT_IMP(a_single_last, out_valid_o && status_o != ST_OUT,
    last_o && word_res_o == '0 && byte_count_o == '0, "non-output result malformed")

  // a short output word is the stop word
  `FCWM_ASSERT_IMP(a_short_stop, out_valid_o && status_o == ST_OUT && byte_count_o != 3'd4,
    last_o, "short output word not last")

  // no new item is taken while an output run is unfinished
  `FCWM_ASSERT_IMP(a_pd_busy, out_valid_o && !last_o, !in_ready_o, "item taken during output run")

endmodule

bind four_char_word_machine_core fcwm_checker u_fcwm_checker (.*);

>>> sim/four_char_word_machine_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_char_word_machine_core_tb
// Self-checking bench for the word machine core: random programs, shadow model.
// ----------------------------------------------------------------------------
// A driver pops items from a queue and offers them with random gaps; every
// accepted item runs through a shadow copy of the machine that queues the
// answers it should produce. A monitor pops those answers in order as the
// core hands results out, with random and long back-pressure. Three phases
// swap the idle rates of the two sides; the last one runs flat out.
module four_char_word_machine_core_tb;
  import fcwm_pkg::*;

  localparam int unsigned STORE_WORDS = 100;
  localparam int unsigned BLOCK_WORDS = 10;
  localparam int          QUIET_LIMIT = 4000;  // cycles with no item moving
  localparam int          HOLD_CYCLES = 300;   // long receiver hold-off

  typedef struct packed {
    fcwm_kind_e        kind;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
  } request_t;

  typedef struct packed {
    fcwm_status_e      status;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  cnt;
    logic              last;
  } answer_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        kind_d = 2'd0;
  logic [ADDR_W-1:0] addr_d = '0;
  logic [WORD_W-1:0] word_d = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        status_o;
  logic [ADDR_W-1:0] address_res_o;
  logic [WORD_W-1:0] word_res_o;
  logic [CNT_W-1:0]  byte_count_o;
  logic              last_o;

  request_t queued_requests[$];
  answer_t  pending_answers[$];
  request_t offered;
  int       queued_items = 0;
  int       fails = 0;
  int       send_idle_pct = 27;
  int       recv_idle_pct = 58;
  int       hold_asks = 0;
  int       hold_seen;
  int       hold_left;
  int       quiet_cycles = 0;

  // shadow machine state
  logic [WORD_W-1:0] mem [STORE_WORDS];
  logic [ADDR_W-1:0] ic;
  logic [WORD_W-1:0] greg;
  logic              greg_full;
  logic              cflag;
  logic              stopped;

  four_char_word_machine_core #(
    .STORE_WORDS(STORE_WORDS),
    .BLOCK_WORDS(BLOCK_WORDS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .kind_i       (kind_d),
    .address_i    (addr_d),
    .word_i       (word_d),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status_o),
    .address_res_o(address_res_o),
    .word_res_o   (word_res_o),
    .byte_count_o (byte_count_o),
    .last_o       (last_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- shadow model

  function automatic void clear_machine();
    for (int i = 0; i < STORE_WORDS; i++) mem[i] = ALL_DOLLARS;
    ic        = '0;
    greg      = '0;
    greg_full = 1'b0;
    cflag     = 1'b0;
    stopped   = 1'b1;
  endfunction

  function automatic void owe(fcwm_status_e st, int unsigned a, logic [WORD_W-1:0] w,
                              int unsigned n, logic lst);
    answer_t ans;
    ans.status = st;
    ans.addr   = a[ADDR_W-1:0];
    ans.word   = w;
    ans.cnt    = n[CNT_W-1:0];
    ans.last   = lst;
    pending_answers.push_back(ans);
  endfunction

  // two-digit operand, -1 when not a store address
  function automatic int operand_of(logic [WORD_W-1:0] instr);
    logic [7:0] hi;
    logic [7:0] lo;
    int         v;
    hi = instr[15:8];
    lo = instr[7:0];
    if (hi < CHAR_ZERO || hi > CHAR_NINE || lo < CHAR_ZERO || lo > CHAR_NINE) return -1;
    v = int'(hi - CHAR_ZERO) * 10 + int'(lo - CHAR_ZERO);
    if (v >= STORE_WORDS) return -1;
    return v;
  endfunction

  function automatic void put_block(int pos);
    int unsigned       base;
    int unsigned       a;
    int unsigned       n;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] mask;
    logic              stop;
    base = (pos / BLOCK_WORDS) * BLOCK_WORDS;
    for (int unsigned i = 0; i < BLOCK_WORDS; i++) begin
      a = base + i;
      w = mem[a];
      n = 0;
      while (n < 4 && w[31 - 8 * n -: 8] != CHAR_NUL && w[31 - 8 * n -: 8] != CHAR_DOLLAR)
        n++;
      mask = (n == 0) ? '0 : (32'hFFFF_FFFF << (32 - 8 * n));
      stop = (n < 4) || (i + 1 >= BLOCK_WORDS) || (a + 1 >= STORE_WORDS);
      owe(ST_OUT, base, w & mask, n, stop);
      if (stop) break;
    end
  endfunction

  function automatic void exec_item(request_t rq);
    logic [ADDR_W-1:0] ia;
    logic [WORD_W-1:0] instr;
    logic [15:0]       opc;
    int                pos;
    case (rq.kind)
      KIND_LOAD: begin
        if (rq.addr < STORE_WORDS) mem[rq.addr] = rq.word;
        owe(ST_DONE, rq.addr, '0, 0, 1'b1);
      end
      KIND_CLEAR: begin
        clear_machine();
        owe(ST_DONE, 0, '0, 0, 1'b1);
      end
      KIND_START: begin
        ic      = '0;
        stopped = 1'b0;
        owe(ST_DONE, 0, '0, 0, 1'b1);
      end
      default: begin
        ia = ic;
        if (stopped) begin
          owe(ST_HALT, ia, '0, 0, 1'b1);
        end else if (ia >= STORE_WORDS) begin
          stopped = 1'b1;
          owe(ST_ADDRERR, ia, '0, 0, 1'b1);
        end else begin
          instr = mem[ia];
          ic    = ia + 1'b1;
          opc   = instr[31:16];
          pos   = operand_of(instr);
          if (opc != OPC_LR && opc != OPC_SR && opc != OPC_CR && opc != OPC_BT &&
              opc != OPC_GD && opc != OPC_PD) begin
            stopped = 1'b1;
            owe(ST_HALT, ia, '0, 0, 1'b1);
          end else if (opc == OPC_BT && !cflag) begin
            owe(ST_DONE, ia, '0, 0, 1'b1);  // untaken branch ignores its operand
          end else if (pos < 0) begin
            stopped = 1'b1;
            owe(ST_ADDRERR, ia, '0, 0, 1'b1);
          end else if (opc == OPC_GD) begin
            owe(ST_INREQ, (pos / BLOCK_WORDS) * BLOCK_WORDS, '0, 0, 1'b1);
          end else if (opc == OPC_PD) begin
            put_block(pos);
          end else begin
            if (opc == OPC_LR) begin
              greg      = mem[pos];
              greg_full = 1'b1;
            end else if (opc == OPC_SR) begin
              mem[pos] = greg;
            end else if (opc == OPC_CR) begin
              cflag = greg_full && (greg == mem[pos]);
            end else begin
              ic = pos[ADDR_W-1:0];
            end
            owe(ST_DONE, ia, '0, 0, 1'b1);
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void add_req(fcwm_kind_e k, logic [ADDR_W-1:0] a, logic [WORD_W-1:0] w);
    request_t rq;
    rq.kind = k;
    rq.addr = a;
    rq.word = w;
    queued_requests.push_back(rq);
    queued_items++;
  endfunction

  // clear, start and step carry junk in the unused fields
  function automatic void add_ctl(fcwm_kind_e k);
    add_req(k, ADDR_W'($urandom()), $urandom());
  endfunction

  function automatic logic [WORD_W-1:0] instr_word(logic [15:0] opc, int v);
    return {opc, 8'(CHAR_ZERO + v / 10), 8'(CHAR_ZERO + v % 10)};
  endfunction

  function automatic logic [7:0] any_char();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return CHAR_DOLLAR;
    if (r == 1) return CHAR_NUL;
    if (r == 2) return 8'($urandom());
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  function automatic logic [7:0] clean_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    return (c == CHAR_DOLLAR) ? 8'h41 : c;
  endfunction

  function automatic logic [WORD_W-1:0] data_word();
    return {any_char(), any_char(), any_char(), any_char()};
  endfunction

  function automatic logic [WORD_W-1:0] prog_word(int len, ref int lr_pos);
    logic [15:0] opc;
    int          v;
    case ($urandom_range(0, 5))
      0:       opc = OPC_LR;
      1:       opc = OPC_SR;
      2:       opc = OPC_CR;
      3:       opc = OPC_BT;
      4:       opc = OPC_GD;
      default: opc = OPC_PD;
    endcase
    if ($urandom_range(0, 99) < 7) opc = 16'($urandom());  // mostly unknown opcodes
    if (opc == OPC_BT)
      v = ($urandom_range(0, 9) < 8) ? $urandom_range(0, len - 1) : $urandom_range(0, 99);
    else if (opc == OPC_CR && $urandom_range(0, 1) == 0)
      v = lr_pos;  // compare against what was just loaded, so branches get taken
    else
      v = ($urandom_range(0, 9) < 8) ? $urandom_range(20, 99) : $urandom_range(0, 99);
    if (opc == OPC_LR) lr_pos = v;
    if ($urandom_range(0, 99) < 8) begin
      // operand with at least one non-digit character
      if ($urandom_range(0, 1) == 0)
        return {opc, any_char(), 8'($urandom_range(8'h3A, 8'hFF))};
      return {opc, 8'($urandom_range(0, 8'h2F)), 8'(CHAR_ZERO + v % 10)};
    end
    return instr_word(opc, v);
  endfunction

  // one program: code at the bottom of the store, data above, then a run of steps
  task automatic queue_program();
    int len;
    int lr_pos;
    int base;
    lr_pos = $urandom_range(20, 99);
    if ($urandom_range(0, 2) == 0) add_ctl(KIND_CLEAR);
    len = $urandom_range(3, 12);
    for (int a = 0; a < len; a++) add_req(KIND_LOAD, ADDR_W'(a), prog_word(len, lr_pos));
    if ($urandom_range(0, 2) == 0) begin
      // a block with no stop character, sometimes cut short at its end
      base = 10 * $urandom_range(2, 9);
      for (int i = 0; i < BLOCK_WORDS; i++)
        add_req(KIND_LOAD, ADDR_W'(base + i),
                {clean_char(), clean_char(), clean_char(),
                 (i == BLOCK_WORDS - 1 && $urandom_range(0, 1) == 0) ? any_char()
                                                                      : clean_char()});
    end
    repeat ($urandom_range(1, 4)) add_req(KIND_LOAD, ADDR_W'($urandom_range(20, 99)), data_word());
    if ($urandom_range(0, 9) == 0)
      add_req(KIND_LOAD, ADDR_W'($urandom_range(STORE_WORDS, 127)), $urandom());
    if ($urandom_range(0, 9) != 0) add_ctl(KIND_START);
    repeat ($urandom_range(len, 2 * len + 4)) begin
      add_ctl(KIND_STEP);
      // host answering input requests
      if ($urandom_range(0, 5) == 0)
        add_req(KIND_LOAD, ADDR_W'($urandom_range(20, 99)), data_word());
    end
  endtask

  // LR, CR, a taken BT into the last word, GD there and the counter running off
  // the store; SR and CR on an empty register; PD on a NUL word; load past store.
  task automatic queue_directed();
    add_ctl(KIND_STEP);
    add_req(KIND_LOAD, 7'd127, 32'hFFFF_FFFF);
    add_req(KIND_LOAD, 7'd100, 32'h0000_0000);
    add_req(KIND_LOAD, 7'd0, instr_word(OPC_SR, 60));
    add_req(KIND_LOAD, 7'd1, instr_word(OPC_CR, 61));
    add_req(KIND_LOAD, 7'd2, instr_word(OPC_PD, 60));
    add_req(KIND_LOAD, 7'd3, instr_word(OPC_LR, 70));
    add_req(KIND_LOAD, 7'd4, instr_word(OPC_CR, 70));
    add_req(KIND_LOAD, 7'd5, instr_word(OPC_BT, 99));
    add_req(KIND_LOAD, 7'd99, instr_word(OPC_GD, 95));
    add_req(KIND_LOAD, 7'd70, 32'h4142_4344);
    add_ctl(KIND_START);
    repeat (8) add_ctl(KIND_STEP);
  endtask

  task automatic wait_drained();
    while (queued_requests.size() != 0 || in_valid) @(negedge clk_i);
    while (pending_answers.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) exec_item(offered);
      if (!in_valid || in_ready) begin
        if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered  = queued_requests.pop_front();
          in_valid <= 1'b1;
          kind_d   <= offered.kind;
          addr_d   <= offered.addr;
          word_d   <= offered.word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_answers.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result st=%0d ad=%0d w=%h n=%0d l=%0d", $realtime,
                     status_o, address_res_o, word_res_o, byte_count_o, last_o);
        end else begin
          want = pending_answers.pop_front();
          if (status_o !== want.status || address_res_o !== want.addr ||
              word_res_o !== want.word || byte_count_o !== want.cnt ||
              last_o !== want.last) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch got st=%0d ad=%0d w=%h n=%0d l=%0d, want st=%0d ad=%0d w=%h n=%0d l=%0d",
                       $realtime, status_o, address_res_o, word_res_o, byte_count_o, last_o,
                       want.status, want.addr, want.word, want.cnt, want.last);
          end
        end
      end
      if (hold_seen != hold_asks) begin
        hold_seen <= hold_asks;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int target;
    clear_machine();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    queue_directed();
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_asks++;  // receiver stalls long while the sender keeps offering
        end
      endcase
      target = queued_items + 133;
      while (queued_items < target) queue_program();
      wait_drained();  // sender pauses until every answer is back
    end
    repeat (40) @(negedge clk_i);
    fails += pending_answers.size();
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
